>>> rtl/fvts_pkg.sv
// ----------------------------------------------------------------------------
// fvts_pkg
// Shared constants, codes, state type and control structs of the vector
// search block.
// ----------------------------------------------------------------------------
package fvts_pkg;

  localparam int DIM_MAX   = 64;
  localparam int CAPACITY  = 1024;
  localparam int K_MAX     = 16;
  localparam int ELEM_BITS = 16;

  localparam int ID_W       = 32;
  localparam int SCORE_W    = 48;
  localparam int STATUS_W   = 2;
  localparam int TOPK_W     = 5;
  localparam int DIM_W      = 7;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam int IDX_W      = $clog2(DIM_MAX);
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int ADDR_W     = SLOT_W + IDX_W;
  localparam int K_W        = $clog2(K_MAX + 1);
  localparam int LIST_IDX_W = $clog2(K_MAX);
  localparam int EXT_W      = ELEM_BITS + 1;
  localparam int PROD_W     = 2 * EXT_W;
  localparam int MAG_W      = 40;
  localparam int ROOT_W     = MAG_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int NUM_W      = 2 * ELEM_BITS;
  localparam int STEP_W     = $clog2(NUM_W);
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int Q_MAX      = (1 << (ELEM_BITS - 1)) - 1;
  localparam int COS_SHIFT  = 6;

  localparam logic [MODE_W-1:0] MODE_L2  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DOT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COS = 2'd2;

  localparam logic [STATUS_W-1:0] RES_HIT   = 2'd0;
  localparam logic [STATUS_W-1:0] RES_ADDED = 2'd1;
  localparam logic [STATUS_W-1:0] RES_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] RES_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIM  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SQRT,
    S_XFER_RD,
    S_XFER_CALC,
    S_DIV,
    S_XFER_WR,
    S_SCAN_RD,
    S_SCAN_MUL,
    S_SCAN_ACC,
    S_SCAN_INS,
    S_EMIT,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic                in_ready;
    logic                out_valid;
    logic                vec_clr;
    logic                sqrt_init;
    logic                sqrt_step;
    logic                ebuf_rd;
    logic                val_load;
    logic                div_init;
    logic                div_step;
    logic                vec_wr;
    logic                commit;
    logic                reply_set;
    logic [STATUS_W-1:0] reply_code;
    logic                list_clr;
    logic                acc_clr;
    logic                scan_rd;
    logic                mul;
    logic                acc_add;
    logic                ins;
    logic                emit_list;
    logic                emit_adv;
    logic [IDX_W-1:0]    idx;
    logic [SLOT_W-1:0]   slot;
  } cmd_t;

  typedef struct packed {
    logic accept_last;
    logic is_query;
    logic full;
    logic cos;
    logic k_zero;
    logic count_zero;
    logic slot_last;
    logic emit_last;
    logic out_ready;
  } stat_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return DIM_W'(1);
    end else if (d > DIM_W'(DIM_MAX)) begin
      return DIM_W'(DIM_MAX);
    end
    return d;
  endfunction

endpackage

>>> rtl/fvts_if.sv
// ----------------------------------------------------------------------------
// fvts_if
// Request and response channels of the vector search block.
// ----------------------------------------------------------------------------
interface fvts_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic signed [fvts_pkg::ELEM_BITS-1:0] elem_value;
  logic [fvts_pkg::ID_W-1:0]            vec_id;
  logic [fvts_pkg::TOPK_W-1:0]          top_k;
  logic                                 elem_last;

  modport source (output valid, req_type, elem_value, vec_id, top_k, elem_last,
                  input ready);
  modport sink   (input valid, req_type, elem_value, vec_id, top_k, elem_last,
                  output ready);
endinterface

interface fvts_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [fvts_pkg::ID_W-1:0]           result_id;
  logic signed [fvts_pkg::SCORE_W-1:0] result_score;
  logic [fvts_pkg::STATUS_W-1:0]       status;
  logic                                result_last;

  modport source (output valid, result_id, result_score, status, result_last,
                  input ready);
  modport sink   (input valid, result_id, result_score, status, result_last,
                  output ready);
endinterface

>>> rtl/fvts_ctrl.sv
// ----------------------------------------------------------------------------
// fvts_ctrl
// Sequencer: collects elements, normalizes in cosine mode, stores or scans, then replies.
// ----------------------------------------------------------------------------
module fvts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  fvts_pkg::stat_t stat,
  output fvts_pkg::cmd_t  cmd
);
  import fvts_pkg::*;

  state_t              state, state_next;
  logic [IDX_W-1:0]    i, i_next;
  logic [STEP_W-1:0]   cnt, cnt_next;
  logic [SLOT_W-1:0]   slot, slot_next;
  logic                i_last;

  assign i_last = (i == IDX_W'(DIM_MAX - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      cnt   <= '0;
      slot  <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      cnt   <= cnt_next;
      slot  <= slot_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (stat.accept_last) state_next = S_DECIDE;
      S_DECIDE: begin
        if (!stat.is_query && stat.full) begin
          state_next = S_REPLY;
        end else if (stat.cos) begin
          state_next = S_SQRT;
        end else begin
          state_next = S_XFER_RD;
        end
      end
      S_SQRT:      if (cnt == STEP_W'(SQRT_STEPS - 1)) state_next = S_XFER_RD;
      S_XFER_RD:   state_next = S_XFER_CALC;
      S_XFER_CALC: state_next = stat.cos ? S_DIV : S_XFER_WR;
      S_DIV:       if (cnt == STEP_W'(DIV_STEPS - 1)) state_next = S_XFER_WR;
      S_XFER_WR: begin
        if (!i_last) begin
          state_next = S_XFER_RD;
        end else if (!stat.is_query || stat.k_zero || stat.count_zero) begin
          state_next = S_REPLY;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD:   state_next = S_SCAN_MUL;
      S_SCAN_MUL:  state_next = S_SCAN_ACC;
      S_SCAN_ACC:  state_next = i_last ? S_SCAN_INS : S_SCAN_RD;
      S_SCAN_INS:  state_next = stat.slot_last ? S_EMIT : S_SCAN_RD;
      S_EMIT:      if (stat.out_ready && stat.emit_last) state_next = S_IDLE;
      S_REPLY:     if (stat.out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    i_next    = i;
    cnt_next  = cnt;
    slot_next = slot;
    case (state)
      S_DECIDE: begin
        i_next   = '0;
        cnt_next = '0;
      end
      S_SQRT, S_DIV: cnt_next = cnt + STEP_W'(1);
      S_XFER_CALC:   cnt_next = '0;
      S_XFER_WR: begin
        i_next    = i_last ? '0 : i + IDX_W'(1);
        slot_next = '0;
      end
      S_SCAN_ACC:    i_next = i_last ? '0 : i + IDX_W'(1);
      S_SCAN_INS:    slot_next = slot + SLOT_W'(1);
      default: ;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.idx  = i;
    cmd.slot = slot;
    unique case (state)
      S_IDLE:      cmd.in_ready = 1'b1;
      S_DECIDE: begin
        cmd.sqrt_init  = 1'b1;
        cmd.reply_set  = !stat.is_query && stat.full;
        cmd.reply_code = RES_FULL;
      end
      S_SQRT:      cmd.sqrt_step = 1'b1;
      S_XFER_RD:   cmd.ebuf_rd = 1'b1;
      S_XFER_CALC: begin
        cmd.val_load = 1'b1;
        cmd.div_init = 1'b1;
      end
      S_DIV:       cmd.div_step = 1'b1;
      S_XFER_WR: begin
        cmd.vec_wr = 1'b1;
        if (i_last) begin
          cmd.commit     = !stat.is_query;
          cmd.reply_set  = 1'b1;
          cmd.reply_code = stat.is_query ? RES_NONE : RES_ADDED;
          cmd.list_clr   = 1'b1;
          cmd.acc_clr    = 1'b1;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        cmd.vec_clr = 1'b1;
      end
      S_SCAN_MUL:  cmd.mul = 1'b1;
      S_SCAN_ACC:  cmd.acc_add = 1'b1;
      S_SCAN_INS: begin
        cmd.ins     = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      S_EMIT: begin
        cmd.out_valid = 1'b1;
        cmd.emit_list = 1'b1;
        cmd.emit_adv  = stat.out_ready;
      end
      S_REPLY: begin
        cmd.out_valid = 1'b1;
        cmd.vec_clr   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/fvts_dp.sv
// ----------------------------------------------------------------------------
// fvts_dp
// Datapath: registers, element buffer, stores, square root, divider,
// score unit and sorted best list.
// ----------------------------------------------------------------------------
module fvts_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [fvts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fvts_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  req_valid,
  input  logic                                  req_type,
  input  logic signed [fvts_pkg::ELEM_BITS-1:0] elem_value,
  input  logic [fvts_pkg::ID_W-1:0]             vec_id,
  input  logic [fvts_pkg::TOPK_W-1:0]           top_k,
  input  logic                                  elem_last,
  input  logic                                  rsp_ready,
  output logic [fvts_pkg::ID_W-1:0]             result_id,
  output logic signed [fvts_pkg::SCORE_W-1:0]   result_score,
  output logic [fvts_pkg::STATUS_W-1:0]         status,
  output logic                                  result_last,
  input  fvts_pkg::cmd_t                        cmd,
  output fvts_pkg::stat_t                       stat
);
  import fvts_pkg::*;

  logic [DIM_W-1:0]  vector_dim;
  logic [MODE_W-1:0] metric_mode;
  logic [DIM_W-1:0]  dim_eff;
  logic              is_cos, is_l2, accept, take_ok;

  logic [DIM_W-1:0]         ecount;
  logic [MAG_W-1:0]         magsum;
  logic [ELEM_BITS-1:0]     ax;
  logic [2*ELEM_BITS-1:0]   sq;
  logic signed [ELEM_BITS-1:0] ebuf [DIM_MAX];
  logic signed [ELEM_BITS-1:0] ebuf_q;

  logic                  is_query;
  logic [ID_W-1:0]       id_lat;
  logic [K_W-1:0]        k_lat;
  logic [CNT_W-1:0]      count;

  logic [MAG_W-1:0]      sq_a;
  logic [REM_W-1:0]      sq_rem;
  logic [ROOT_W-1:0]     sq_root;
  logic [REM_W+1:0]      rem_sh, trial;

  logic [NUM_W-1:0]      num, quo;
  logic [ROOT_W:0]       drem;
  logic [ROOT_W+1:0]     r_sh;
  logic                  ge;

  logic signed [ELEM_BITS-1:0] vsel, vreg, nval, wr_val;
  logic [ELEM_BITS-1:0]        ax_v, nq;

  logic signed [ELEM_BITS-1:0] qbuf [DIM_MAX];
  logic signed [ELEM_BITS-1:0] vstore [DIM_MAX * CAPACITY];
  logic [ID_W-1:0]             id_store [CAPACITY];
  logic signed [ELEM_BITS-1:0] qd, sd;
  logic [ID_W-1:0]             idq;

  logic signed [EXT_W-1:0]   diff, ma, mb;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SCORE_W-1:0] term, acc, sc;

  logic [ID_W-1:0]           lid [K_MAX];
  logic signed [SCORE_W-1:0] lsc [K_MAX];
  logic [K_W-1:0]            fill, ins_pos;
  logic [K_MAX-1:0]          better;
  logic [LIST_IDX_W-1:0]     oidx;
  logic                      emit_last;

  logic [STATUS_W-1:0] reply_code;
  logic [ID_W-1:0]     reply_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_dim  <= DIM_W'(DIM_MAX);
      metric_mode <= MODE_L2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIM:  vector_dim  <= cfg_data[DIM_W-1:0];
        REG_MODE: metric_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign dim_eff = eff_dim(vector_dim);
  assign is_cos  = (metric_mode == MODE_COS);
  assign is_l2   = (metric_mode == MODE_L2);
  assign accept  = req_valid && cmd.in_ready;
  assign take_ok = (ecount < dim_eff);
  assign ax      = elem_value[ELEM_BITS-1] ? ELEM_BITS'(-elem_value) : elem_value;
  assign sq      = ax * ax;

  always_ff @(posedge clk) begin
    if (rst || cmd.vec_clr) begin
      ecount <= '0;
      magsum <= '0;
    end else if (accept && take_ok) begin
      ecount <= ecount + DIM_W'(1);
      magsum <= magsum + MAG_W'(sq);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && take_ok) begin
      ebuf[ecount[IDX_W-1:0]] <= elem_value;
    end
    if (cmd.ebuf_rd) begin
      ebuf_q <= ebuf[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && elem_last) begin
      is_query <= req_type;
      id_lat   <= vec_id;
      k_lat    <= (top_k > TOPK_W'(K_MAX)) ? K_W'(K_MAX) : K_W'(top_k);
    end
  end

  // square root, two radicand bits per step
  assign rem_sh = {sq_rem, sq_a[MAG_W-1 -: 2]};
  assign trial  = {2'b00, sq_root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_a    <= magsum;
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sqrt_step) begin
      sq_a <= sq_a << 2;
      if (rem_sh >= trial) begin
        sq_rem  <= REM_W'(rem_sh - trial);
        sq_root <= {sq_root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem  <= REM_W'(rem_sh);
        sq_root <= {sq_root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign vsel = ((DIM_W'(cmd.idx) < ecount) && (DIM_W'(cmd.idx) < dim_eff)) ? ebuf_q : '0;
  assign ax_v = vsel[ELEM_BITS-1] ? ELEM_BITS'(-vsel) : vsel;

  // restoring divider, one quotient bit per step
  assign r_sh = {drem, num[NUM_W-1]};
  assign ge   = (r_sh >= (ROOT_W+2)'(sq_root));

  always_ff @(posedge clk) begin
    if (cmd.val_load) begin
      vreg <= vsel;
    end
    if (cmd.div_init) begin
      num  <= NUM_W'({ax_v, {(ELEM_BITS-1){1'b0}}}) + NUM_W'(sq_root >> 1);
      drem <= '0;
      quo  <= '0;
    end else if (cmd.div_step) begin
      num  <= num << 1;
      drem <= ge ? (ROOT_W+1)'(r_sh - (ROOT_W+2)'(sq_root)) : (ROOT_W+1)'(r_sh);
      quo  <= {quo[NUM_W-2:0], ge};
    end
  end

  assign nq     = (sq_root == '0) ? '0 :
                  (quo > NUM_W'(Q_MAX)) ? ELEM_BITS'(Q_MAX) : quo[ELEM_BITS-1:0];
  assign nval   = vreg[ELEM_BITS-1] ? -$signed(nq) : $signed(nq);
  assign wr_val = is_cos ? nval : vreg;

  always_ff @(posedge clk) begin
    if (cmd.vec_wr && is_query) begin
      qbuf[cmd.idx] <= wr_val;
    end
    if (cmd.scan_rd) begin
      qd <= qbuf[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vec_wr && !is_query) begin
      vstore[{count[SLOT_W-1:0], cmd.idx}] <= wr_val;
    end
    if (cmd.scan_rd) begin
      sd <= vstore[{cmd.slot, cmd.idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      id_store[count[SLOT_W-1:0]] <= id_lat;
    end
    if (cmd.scan_rd) begin
      idq <= id_store[cmd.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count + CNT_W'(1);
    end
  end

  assign diff = EXT_W'(qd) - EXT_W'(sd);
  assign ma   = is_l2 ? diff : EXT_W'(qd);
  assign mb   = is_l2 ? diff : EXT_W'(sd);
  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      term <= SCORE_W'(prod);
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + term;
    end
  end

  assign sc = is_cos ? (acc >>> COS_SHIFT) : acc;

  always_comb begin
    ins_pos = fill;
    for (int j = 0; j < K_MAX; j++) begin
      better[j] = (K_W'(j) < fill) && (is_l2 ? (sc < lsc[j]) : (sc > lsc[j]));
    end
    for (int j = K_MAX - 1; j >= 0; j--) begin
      if (better[j]) ins_pos = K_W'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.list_clr) begin
      fill <= '0;
      oidx <= '0;
    end else begin
      if (cmd.ins && (ins_pos < k_lat) && (fill < k_lat)) begin
        fill <= fill + K_W'(1);
      end
      if (cmd.emit_adv) begin
        oidx <= oidx + LIST_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins && (ins_pos < k_lat)) begin
      if (ins_pos == '0) begin
        lid[0] <= idq;
        lsc[0] <= sc;
      end
      for (int j = 1; j < K_MAX; j++) begin
        if (K_W'(j) == ins_pos) begin
          lid[j] <= idq;
          lsc[j] <= sc;
        end else if (K_W'(j) > ins_pos) begin
          lid[j] <= lid[j-1];
          lsc[j] <= lsc[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reply_set) begin
      reply_code <= cmd.reply_code;
      reply_id   <= (cmd.reply_code == RES_NONE) ? '0 : id_lat;
    end
  end

  assign emit_last    = (K_W'(oidx) + K_W'(1) == fill);
  assign result_id    = cmd.emit_list ? lid[oidx] : reply_id;
  assign result_score = cmd.emit_list ? lsc[oidx] : '0;
  assign status       = cmd.emit_list ? RES_HIT : reply_code;
  assign result_last  = cmd.emit_list ? emit_last : 1'b1;

  assign stat.accept_last = accept && elem_last;
  assign stat.is_query    = is_query;
  assign stat.full        = (count == CNT_W'(CAPACITY));
  assign stat.cos         = is_cos;
  assign stat.k_zero      = (k_lat == '0);
  assign stat.count_zero  = (count == '0);
  assign stat.slot_last   = (CNT_W'(cmd.slot) + CNT_W'(1) == count);
  assign stat.emit_last   = emit_last;
  assign stat.out_ready   = rsp_ready;

endmodule

>>> rtl/flat_vector_topk_search.sv
// ----------------------------------------------------------------------------
// flat_vector_topk_search
// Exhaustive top-k vector search over a store of id-tagged vectors.
//
// req carries one vector element per item; elem_last closes a vector.
// req_type 0 adds the vector to the store, 1 runs a query. rsp returns one
// item per add (added or store full) and, for a query, the best top_k entries
// (at most 16, no more than are stored) best first, or one no-results item.
// cfg_we writes vector_dim (index 0) or metric_mode (index 1); the user must
// do so only while the block is idle, as the block does not enforce it.
// Elements are taken one per cycle while req.ready is high; req.ready drops
// after the last element until the final response item is taken. After the
// last element: a decide state, a square root in cosine mode, then per
// element position (DIM_MAX = 64) a read, a calculate step, the
// one-bit-per-cycle divider in cosine mode and a write. A query then scans
// every stored vector: per position a read, multiply and accumulate through
// the single store read port and multiplier, then an insert. Responses wait
// in place while rsp.ready is low; nothing is lost. Reset empties the store,
// clears the element count and sets vector_dim 64, metric_mode squared L2.
// ----------------------------------------------------------------------------
module flat_vector_topk_search (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fvts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fvts_pkg::CFG_DATA_W-1:0]  cfg_data,
  fvts_req_if.sink                         req,
  fvts_rsp_if.source                       rsp
);
  import fvts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fvts_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  fvts_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req.valid),
    .req_type     (req.req_type),
    .elem_value   (req.elem_value),
    .vec_id       (req.vec_id),
    .top_k        (req.top_k),
    .elem_last    (req.elem_last),
    .rsp_ready    (rsp.ready),
    .result_id    (rsp.result_id),
    .result_score (rsp.result_score),
    .status       (rsp.status),
    .result_last  (rsp.result_last),
    .cmd          (cmd),
    .stat         (stat)
  );

  assign req.ready = cmd.in_ready;
  assign rsp.valid = cmd.out_valid;

endmodule

>>> rtl/fvts_chk.sv
// ----------------------------------------------------------------------------
// fvts_chk
// Port-level checks of the vector search block, bound to the top level.
// ----------------------------------------------------------------------------
module fvts_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               req_last,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [fvts_pkg::ID_W-1:0]          result_id,
  input logic [fvts_pkg::SCORE_W-1:0]       result_score,
  input logic [fvts_pkg::STATUS_W-1:0]      status,
  input logic                               result_last
);
  import fvts_pkg::*;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request taken while a response is pending");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_id) &&
      $stable(result_score) && $stable(status) && $stable(result_last))
    else $error("stalled response changed");

  a_single_reply: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == RES_ADDED || status == RES_FULL || status == RES_NONE)
      |-> result_last)
    else $error("single-item reply not marked last");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_last |=> !req_ready)
    else $error("request taken right after a closing element");

endmodule

bind flat_vector_topk_search fvts_chk u_fvts_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_last     (req.elem_last),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .result_id    (rsp.result_id),
  .result_score (rsp.result_score),
  .status       (rsp.status),
  .result_last  (rsp.result_last)
);
